@@ rtl/mme_pkg.sv @@
// ---------------------------------------------------------------------------
// Matrix multiply engine package
// Shared widths, codes, command and status types for the engine.
// ---------------------------------------------------------------------------
package mme_pkg;

  // Default shape limits.
  localparam int DEF_MAX_ROWS  = 8;
  localparam int DEF_MAX_INNER = 16;
  localparam int DEF_MAX_COLS  = 8;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 16;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int SUM_W   = 36;
  localparam int PROD_W  = 2 * VALUE_W;

  // Shape register widths.
  localparam int ROWS_REG_W  = 4;
  localparam int INNER_REG_W = 5;
  localparam int COLS_REG_W  = 4;

  // Configuration bus.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd2;

  // Operation codes on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } mme_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic issue;
    logic emit;
  } mme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_last;
    logic elem_last;
    logic out_free;
  } mme_status_t;

  function automatic int clog2_min1(input int v);
    int r;
    r = $clog2(v);
    return (r < 1) ? 1 : r;
  endfunction

endpackage

@@ rtl/mme_in_if.sv @@
// ---------------------------------------------------------------------------
// Matrix multiply engine input channel
// Valid/ready channel carrying load and compute transactions.
// ---------------------------------------------------------------------------
interface mme_in_if;
  import mme_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);

endinterface

@@ rtl/mme_out_if.sv @@
// ---------------------------------------------------------------------------
// Matrix multiply engine output channel
// Valid/ready channel carrying one result element per transaction.
// ---------------------------------------------------------------------------
interface mme_out_if;
  import mme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [SUM_W-1:0] sum;
  logic                    last;

  modport source (output valid, output out_row, output out_col, output sum, output last,
                  input ready);
  modport sink   (input valid, input out_row, input out_col, input sum, input last,
                  output ready);

endinterface

@@ rtl/mme_ram.sv @@
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mme_ctrl.sv @@
// ---------------------------------------------------------------------------
// Matrix multiply engine controller
// Sequences loads, operand reads, pipeline drain and result hand-off.
// ---------------------------------------------------------------------------
module mme_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mme_pkg::FUNC_W-1:0] in_func_i,
  output logic                       in_ready_o,
  input  mme_pkg::mme_status_t       status_i,
  output mme_pkg::mme_cmd_t          cmd_o
);
  import mme_pkg::*;

  mme_state_e state_q, state_d;
  logic       wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    wait_d     = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_func_i)
            FUNC_LOAD_A: cmd_o.load_a = 1'b1;
            FUNC_LOAD_B: cmd_o.load_b = 1'b1;
            FUNC_COMPUTE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (status_i.k_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Wait for the read data, then the product, then the last accumulate.
        wait_d = !wait_q;
        if (wait_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.elem_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/mme_datapath.sv @@
// ---------------------------------------------------------------------------
// Matrix multiply engine datapath
// Operand stores, address counters, multiply-accumulate and result register.
// ---------------------------------------------------------------------------
module mme_datapath #(
  parameter int MAX_ROWS  = mme_pkg::DEF_MAX_ROWS,
  parameter int MAX_INNER = mme_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mme_pkg::DEF_MAX_COLS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mme_pkg::ROWS_REG_W-1:0]      rows_i,
  input  logic [mme_pkg::INNER_REG_W-1:0]     inner_i,
  input  logic [mme_pkg::COLS_REG_W-1:0]      cols_i,
  input  logic [mme_pkg::POS_W-1:0]           position_i,
  input  logic signed [mme_pkg::VALUE_W-1:0]  value_i,
  input  mme_pkg::mme_cmd_t                   cmd_i,
  output mme_pkg::mme_status_t                status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mme_pkg::ROW_W-1:0]           out_row_o,
  output logic [mme_pkg::COL_W-1:0]           out_col_o,
  output logic signed [mme_pkg::SUM_W-1:0]    sum_o,
  output logic                                last_o
);
  import mme_pkg::*;

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int AAW     = clog2_min1(A_DEPTH);
  localparam int BAW     = clog2_min1(B_DEPTH);
  localparam int RW      = $clog2(MAX_ROWS + 1);
  localparam int NW      = $clog2(MAX_INNER + 1);
  localparam int CW      = $clog2(MAX_COLS + 1);
  localparam int IW      = clog2_min1(MAX_ROWS);
  localparam int KW      = clog2_min1(MAX_INNER);
  localparam int JW      = clog2_min1(MAX_COLS);
  localparam int ALW     = RW + NW;
  localparam int BLW     = NW + CW;

  // Effective shape: zero acts as one, oversize acts as the maximum.
  logic [RW-1:0]  r_eff;
  logic [NW-1:0]  n_eff;
  logic [CW-1:0]  c_eff;
  logic [ALW-1:0] a_lim;
  logic [BLW-1:0] b_lim;

  assign r_eff = (rows_i == '0) ? RW'(1) :
                 (int'(rows_i) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_i);
  assign n_eff = (inner_i == '0) ? NW'(1) :
                 (int'(inner_i) > MAX_INNER) ? NW'(MAX_INNER) : NW'(inner_i);
  assign c_eff = (cols_i == '0) ? CW'(1) :
                 (int'(cols_i) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_i);
  assign a_lim = ALW'(r_eff) * ALW'(n_eff);
  assign b_lim = BLW'(n_eff) * BLW'(c_eff);

  logic a_we, b_we;
  assign a_we = cmd_i.load_a && (int'(position_i) < int'(a_lim));
  assign b_we = cmd_i.load_b && (int'(position_i) < int'(b_lim));

  // Index and address counters.
  logic [IW-1:0]  i_q;
  logic [JW-1:0]  j_q;
  logic [KW-1:0]  k_q;
  logic [AAW-1:0] a_base_q;
  logic [BAW-1:0] b_ptr_q;
  logic [AAW-1:0] a_raddr;
  logic           i_last, j_last;

  assign a_raddr = a_base_q + AAW'(k_q);
  assign i_last  = (int'(i_q) == int'(r_eff) - 1);
  assign j_last  = (int'(j_q) == int'(c_eff) - 1);

  assign status_o.k_last    = (int'(k_q) == int'(n_eff) - 1);
  assign status_o.elem_last = i_last && j_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      a_base_q <= '0;
      b_ptr_q  <= '0;
    end else if (cmd_i.issue) begin
      k_q     <= k_q + KW'(1);
      b_ptr_q <= b_ptr_q + BAW'(c_eff);
    end else if (cmd_i.emit) begin
      k_q <= '0;
      if (j_last) begin
        j_q      <= '0;
        i_q      <= i_q + IW'(1);
        a_base_q <= a_base_q + AAW'(n_eff);
        b_ptr_q  <= '0;
      end else begin
        j_q     <= j_q + JW'(1);
        b_ptr_q <= BAW'(j_q) + BAW'(1);
      end
    end
  end

  // Operand stores.
  logic signed [VALUE_W-1:0] a_rdata, b_rdata;

  mme_ram #(.WIDTH(VALUE_W), .DEPTH(A_DEPTH), .ADDR_W(AAW)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (AAW'(position_i)),
    .wdata_i (value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(.WIDTH(VALUE_W), .DEPTH(B_DEPTH), .ADDR_W(BAW)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (BAW'(position_i)),
    .wdata_i (value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (b_ptr_q),
    .rdata_o (b_rdata)
  );

  // Multiply-accumulate pipeline: read, product register, accumulator.
  logic                     rd_vld_q, rd_first_q, prod_vld_q, prod_first_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q     <= 1'b0;
      rd_first_q   <= 1'b0;
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
    end else begin
      rd_vld_q     <= cmd_i.issue;
      rd_first_q   <= cmd_i.issue && (k_q == '0);
      prod_vld_q   <= rd_vld_q;
      prod_first_q <= rd_first_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_rdata * b_rdata;
    if (prod_vld_q) begin
      if (prod_first_q) begin
        acc_q <= {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end else begin
        acc_q <= acc_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
    end
  end

  // Result register.
  logic out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_o <= ROW_W'(i_q);
      out_col_o <= COL_W'(j_q);
      sum_o     <= acc_q;
      last_o    <= i_last && j_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/matrix_multiply_engine_top.sv @@
// ---------------------------------------------------------------------------
// Matrix multiply engine
// Fixed-point general matrix multiply with element loads and streamed results.
// ---------------------------------------------------------------------------
// The input channel carries three kinds of transaction: a load of one element
// of A, a load of one element of B (each at a flat row-major position, Q8.8),
// and a compute command. Loads outside the configured shape are dropped. A
// compute command streams rows*cols result elements in row-major order on the
// output channel, each an exact Q20.16 dot product, with last set on the
// final one. The shape registers rows, inner and cols are written over the
// APB port at byte addresses 0, 4 and 8; zero acts as one and a value above
// the synthesised maximum acts as that maximum.
// Loads are taken one per cycle while the engine is idle. For each result
// element a compute command reads one operand pair per inner index from the
// two store read ports, then passes the last pair through the registered
// multiplier and the last accumulate and moves the sum into the result
// register. No new transaction is accepted until the last element has been
// handed to the result register. When the receiver stalls, one finished
// element waits in that register while the next is computed, after which
// the engine holds. Reset sets every shape register to one; the store
// contents stay undefined.
// ---------------------------------------------------------------------------
module matrix_multiply_engine_top #(
  parameter int MAX_ROWS  = mme_pkg::DEF_MAX_ROWS,
  parameter int MAX_INNER = mme_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mme_pkg::DEF_MAX_COLS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mme_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mme_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mme_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  mme_in_if.sink                             in_i,
  mme_out_if.source                          out_o
);
  import mme_pkg::*;

  // Shape registers; the user must write them only while the engine is idle, the block does not enforce it.
  logic [ROWS_REG_W-1:0]  rows_q;
  logic [INNER_REG_W-1:0] inner_q;
  logic [COLS_REG_W-1:0]  cols_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_REG_W'(1);
      inner_q <= INNER_REG_W'(1);
      cols_q  <= COLS_REG_W'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ROWS:  rows_q  <= pwdata[ROWS_REG_W-1:0];
        REG_INNER: inner_q <= pwdata[INNER_REG_W-1:0];
        REG_COLS:  cols_q  <= pwdata[COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored register value, zero elsewhere.
  always_comb begin
    case (reg_idx)
      REG_ROWS:  prdata = APB_DATA_W'(rows_q);
      REG_INNER: prdata = APB_DATA_W'(inner_q);
      REG_COLS:  prdata = APB_DATA_W'(cols_q);
      default:   prdata = '0;
    endcase
  end

  mme_cmd_t    cmd;
  mme_status_t status;

  // The controller decides when each transaction is taken and steps the
  // datapath through the read, multiply and accumulate sequence.
  mme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds both operand stores, the counters that walk them,
  // the multiply-accumulate pipeline and the result register.
  mme_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_q),
    .inner_i     (inner_q),
    .cols_i      (cols_q),
    .position_i  (in_i.position),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .sum_o       (out_o.sum),
    .last_o      (out_o.last)
  );

  // A finished element is never moved into an occupied result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> status.out_free)
    else $error("result register overwritten while still pending");

  // A compute command starts reading operands in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.start |=> cmd.issue)
    else $error("compute command did not start the operand reads");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_a, cmd.load_b, cmd.start, cmd.issue, cmd.emit}))
    else $error("conflicting datapath commands");

  // No transaction is taken while a product is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.issue |-> !in_i.ready)
    else $error("input accepted during operand reads");

endmodule
